@@ rtl/sbsm_pkg.sv @@
// shared types and constants for the serial bank switch mapper
package sbsm_pkg;

	// bus operation codes
	localparam logic [1:0] OP_CPU_RD = 2'd0;
	localparam logic [1:0] OP_CPU_WR = 2'd1;
	localparam logic [1:0] OP_PPU_RD = 2'd2;
	localparam logic [1:0] OP_PPU_WR = 2'd3;

	// landing target of an access
	typedef enum logic [2:0] {
		TGT_INVALID = 3'd0,
		TGT_PRG_RAM = 3'd1,
		TGT_PRG_ROM = 3'd2,
		TGT_CHR     = 3'd3,
		TGT_MAPPER  = 3'd4
	} target_t;

	// register picked by address bits 14:13 on the fifth serial write
	localparam logic [1:0] REG_CONTROL = 2'd0;
	localparam logic [1:0] REG_CHR0    = 2'd1;
	localparam logic [1:0] REG_CHR1    = 2'd2;
	localparam logic [1:0] REG_PRG     = 2'd3;

	// prg banking mode that fixes bank 0 low and switches the high window
	localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
	// prg banking mode that fixes the last bank high
	localparam logic [1:0] PRG_MODE_FIX_LAST = 2'd3;

	localparam logic [4:0] SHIFT_MARKER = 5'h10;
	localparam logic [4:0] BANK_COUNT_RST = 5'd16;

	// bank windows and mirroring, as seen by the address translation
	typedef struct packed {
		logic [3:0] prg_window_low;
		logic [3:0] prg_window_high;
		logic [4:0] chr_window_low;
		logic [4:0] chr_window_high;
		logic [1:0] mirror_mode;
	} bank_state_t;

	// one translated access
	typedef struct packed {
		target_t     target;
		logic [17:0] mapped_address;
		logic        write_strobe;
		logic [7:0]  write_data;
		logic        serial_write;
	} xlate_res_t;

endpackage

@@ rtl/sbsm_xlate.sv @@
// address translation of one bus access against the current bank windows
module sbsm_xlate (
	input  logic [1:0]                op,
	input  logic [15:0]               address,
	input  logic [7:0]                data,
	input  sbsm_pkg::bank_state_t     state,
	output sbsm_pkg::xlate_res_t      res
);
	import sbsm_pkg::*;

	logic       is_cpu;
	logic       is_write;
	logic [3:0] prg_win;
	logic [4:0] chr_win;

	assign is_cpu   = (op == OP_CPU_RD) || (op == OP_CPU_WR);
	assign is_write = (op == OP_CPU_WR) || (op == OP_PPU_WR);
	assign prg_win  = address[14] ? state.prg_window_high : state.prg_window_low;
	assign chr_win  = address[12] ? state.chr_window_high : state.chr_window_low;

	// decode the range and build the physical offset
	always_comb begin
		res = '0;
		res.target = TGT_INVALID;
		if (is_cpu) begin
			if (address < 16'h6000) begin
				res.target = TGT_INVALID;
			end else if (address < 16'h8000) begin
				res.target         = TGT_PRG_RAM;
				res.mapped_address = {5'd0, address[12:0]};
				res.write_strobe   = is_write;
			end else if (is_write) begin
				res.target       = TGT_MAPPER;
				res.serial_write = 1'b1;
			end else begin
				res.target         = TGT_PRG_ROM;
				res.mapped_address = {prg_win, address[13:0]};
			end
		end else if (address < 16'h2000) begin
			res.target         = TGT_CHR;
			res.mapped_address = {1'b0, chr_win, address[11:0]};
			res.write_strobe   = is_write;
		end
		res.write_data = res.write_strobe ? data : 8'd0;
	end

endmodule

@@ rtl/sbsm_bank_regs.sv @@
// serial shift register, mapper registers and bank window registers
module sbsm_bank_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  serial_wr,
	input  logic [15:0]           address,
	input  logic [7:0]            data,
	input  logic                  cfg_wr_en,
	input  logic [4:0]            cfg_wr_data,
	output sbsm_pkg::bank_state_t state,
	output logic [1:0]            mirror_next
);
	import sbsm_pkg::*;

	logic [4:0] shift_q;
	logic [4:0] bank_count_q;
	logic [1:0] prg_mode_q;
	logic       chr_mode_q;
	logic [3:0] prg_select_q;
	logic [4:0] chr_sel_low_q;
	logic [4:0] chr_sel_high_q;
	logic       windows_set_q;
	bank_state_t state_q;

	logic [4:0] shift_new;
	logic       load;
	logic [1:0] prg_mode_d;
	logic       chr_mode_d;
	logic [3:0] prg_select_d;
	logic [4:0] chr_sel_low_d;
	logic [4:0] chr_sel_high_d;
	logic [1:0] mirror_d;
	logic [3:0] last_bank;
	logic [3:0] cfg_last_bank;

	assign shift_new     = {data[0], shift_q[4:1]};
	assign load          = serial_wr && !data[7] && shift_q[0];
	assign last_bank     = bank_count_q[3:0] - 4'd1;
	assign cfg_last_bank = cfg_wr_data[3:0] - 4'd1;

	// register values after a fifth serial write
	always_comb begin
		prg_mode_d     = prg_mode_q;
		chr_mode_d     = chr_mode_q;
		prg_select_d   = prg_select_q;
		chr_sel_low_d  = chr_sel_low_q;
		chr_sel_high_d = chr_sel_high_q;
		mirror_d       = state_q.mirror_mode;
		case (address[14:13])
			REG_CONTROL: begin
				mirror_d   = shift_new[1:0];
				prg_mode_d = shift_new[3:2];
				chr_mode_d = shift_new[4];
			end
			REG_CHR0: chr_sel_low_d  = shift_new;
			REG_CHR1: chr_sel_high_d = shift_new;
			REG_PRG:  prg_select_d   = shift_new[3:0];
			default:  mirror_d       = state_q.mirror_mode;
		endcase
	end

	assign mirror_next = load ? mirror_d : state_q.mirror_mode;
	assign state       = state_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q        <= SHIFT_MARKER;
			bank_count_q   <= BANK_COUNT_RST;
			prg_mode_q     <= '0;
			chr_mode_q     <= 1'b0;
			prg_select_q   <= '0;
			chr_sel_low_q  <= '0;
			chr_sel_high_q <= '0;
			windows_set_q  <= 1'b0;
			state_q        <= '{prg_window_low: 4'd0, prg_window_high: 4'd15,
				chr_window_low: 5'd0, chr_window_high: 5'd0, mirror_mode: 2'd0};
		end else if (cfg_wr_en) begin
			bank_count_q <= cfg_wr_data;
			if (!windows_set_q || prg_mode_q == PRG_MODE_FIX_LAST) begin
				state_q.prg_window_high <= cfg_last_bank;
			end
		end else if (serial_wr) begin
			if (data[7]) begin
				shift_q <= SHIFT_MARKER;
			end else if (!shift_q[0]) begin
				shift_q <= shift_new;
			end else begin
				shift_q             <= SHIFT_MARKER;
				prg_mode_q          <= prg_mode_d;
				chr_mode_q          <= chr_mode_d;
				prg_select_q        <= prg_select_d;
				chr_sel_low_q       <= chr_sel_low_d;
				chr_sel_high_q      <= chr_sel_high_d;
				windows_set_q       <= 1'b1;
				state_q.mirror_mode <= mirror_d;
				// recompute prg windows
				case (prg_mode_d)
					PRG_MODE_FIX_FIRST: begin
						state_q.prg_window_low  <= 4'd0;
						state_q.prg_window_high <= prg_select_d;
					end
					PRG_MODE_FIX_LAST: begin
						state_q.prg_window_low  <= prg_select_d;
						state_q.prg_window_high <= last_bank;
					end
					default: begin
						state_q.prg_window_low  <= {prg_select_d[3:1], 1'b0};
						state_q.prg_window_high <= {prg_select_d[3:1], 1'b1};
					end
				endcase
				// recompute chr windows
				if (!chr_mode_d) begin
					state_q.chr_window_low  <= {chr_sel_low_d[4:1], 1'b0};
					state_q.chr_window_high <= {chr_sel_low_d[4:1], 1'b1};
				end else begin
					state_q.chr_window_low  <= chr_sel_low_d;
					state_q.chr_window_high <= chr_sel_high_d;
				end
			end
		end
	end

endmodule

@@ rtl/serial_bank_switch_mapper.sv @@
// top level of the serial bank switch mapper: input stage, translation, result register
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid / in_stall | op, address, data
//  out     | out_valid/out_stall | target, mapped_address, write_strobe, write_data,
//          |                     | mirroring
//  cfg     | cfg_wr_en           | cfg_wr_data (prg bank count)
//
// one beat per cycle while out_stall is low, through the input and result registers
// the input register and the result register each hold one beat; the bank registers
// are updated as a beat moves from the input register into the result register
// a stalled result holds; the input register still takes a beat while it is empty
// reset presets all control state and loads the power-on bank windows at once
module serial_bank_switch_mapper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [15:0]         address,
	input  logic [7:0]          data,
	output logic                out_valid,
	input  logic                out_stall,
	output sbsm_pkg::target_t   target,
	output logic [17:0]         mapped_address,
	output logic                write_strobe,
	output logic [7:0]          write_data,
	output logic [1:0]          mirroring,
	input  logic                cfg_wr_en,
	input  logic [4:0]          cfg_wr_data
);
	import sbsm_pkg::*;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;
	logic        out_valid_q;
	target_t     target_q;
	logic [17:0] mapped_q;
	logic        strobe_q;
	logic [7:0]  wdata_q;
	logic [1:0]  mirror_q;
	logic        advance;
	logic        serial_wr;
	logic [1:0]  mirror_next;
	bank_state_t state;
	xlate_res_t  res;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign serial_wr = advance && valid_s1 && res.serial_write;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1      <= op;
			address_s1 <= address;
			data_s1    <= data;
		end
	end

	sbsm_xlate u_xlate (
		.op      (op_s1),
		.address (address_s1),
		.data    (data_s1),
		.state   (state),
		.res     (res)
	);

	sbsm_bank_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.serial_wr   (serial_wr),
		.address     (address_s1),
		.data        (data_s1),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.state       (state),
		.mirror_next (mirror_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			target_q <= res.target;
			mapped_q <= res.mapped_address;
			strobe_q <= res.write_strobe;
			wdata_q  <= res.write_data;
			mirror_q <= mirror_next;
		end
	end

	assign out_valid      = out_valid_q;
	assign target         = target_q;
	assign mapped_address = mapped_q;
	assign write_strobe   = strobe_q;
	assign write_data     = wdata_q;
	assign mirroring      = mirror_q;

	// checks
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room in the pipe");

	a_strobe_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && write_strobe |-> target_q == TGT_PRG_RAM || target_q == TGT_CHR)
		else $error("write strobe on a target that is not memory");

	a_wdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !write_strobe |-> write_data == 8'd0)
		else $error("write data not cleared without strobe");

	a_reg_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (target_q == TGT_MAPPER || target_q == TGT_INVALID)
			|-> mapped_q == 18'd0)
		else $error("nonzero offset on register or invalid access");

	a_serial_only_cpu: assert property (@(posedge clk) disable iff (!arst_n)
		serial_wr |-> op_s1 == OP_CPU_WR && address_s1[15])
		else $error("serial write from a non mapper access");

endmodule
